[hw/rtl/node_pool_free_list_core_defines.svh]
// Assertion macros for the node pool free list core.
// Included by modules that carry concurrent checks.
`ifndef NODE_POOL_FREE_LIST_CORE_DEFINES_SVH
`define NODE_POOL_FREE_LIST_CORE_DEFINES_SVH
// implication checked on every edge outside reset
`define NPFL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define NPFL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[hw/rtl/npfl_pkg.sv]
// Package for the node pool free list core: widths, codes, command types.
// No dependencies.
`timescale 1ns / 1ps
package npfl_pkg;
  localparam int unsigned PoolNodesDef = 1024;
  localparam int unsigned CntW = 11;
  localparam logic [CntW-1:0] CountMax = 11'd2047;
  localparam int unsigned ActW = 2;
  localparam int unsigned IdxW = 10;
  localparam int unsigned BytesW = 23;
  localparam int unsigned CfgW = 4;

  localparam logic [ActW-1:0] ActInsert  = 2'd0;
  localparam logic [ActW-1:0] ActAlloc   = 2'd1;
  localparam logic [ActW-1:0] ActDealloc = 2'd2;

  // controller -> datapath commands
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdRdHead, CmdPop, CmdPush, CmdThrInit, CmdThrStep,
    CmdThrEnd, CmdSrchInit, CmdSrchRd, CmdSrchStep, CmdUnlink, CmdFail, CmdReject
  } cmd_e;

  typedef struct packed {
    logic head_null;
    logic small_req;
    logic idx_bad;
    logic cnt_zero;
    logic thr_last;
    logic srch_end;
    logic srch_hit;
    logic [ActW-1:0] action;
  } status_t;
endpackage

[hw/rtl/npfl_if.sv]
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing.
`timescale 1ns / 1ps
interface npfl_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/npfl_ctrl.sv]
// Controller state machine of the node pool free list core.
// Depends on npfl_pkg and node_pool_free_list_core_defines.svh.
`timescale 1ns / 1ps
`include "node_pool_free_list_core_defines.svh"
module npfl_ctrl import npfl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  input  status_t st_i,
  output cmd_e    cmd_o
);
  typedef enum logic [2:0] {
    SIdle, SDecode, SThread, SSrchRd, SSrch, SUnlink, SOut
  } state_e;
  state_e state_q;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    cmd_o = CmdNone;
    unique case (state_q)
      SIdle: if (in_valid_i) cmd_o = CmdLoad;
      SDecode: begin
        priority if (st_i.action == ActAlloc) begin
          priority if (st_i.head_null) cmd_o = CmdFail;
          else if (st_i.small_req) cmd_o = CmdPop;
          else cmd_o = CmdSrchInit;
        end else if (st_i.action == ActInsert || st_i.action == ActDealloc) begin
          priority if (st_i.idx_bad) cmd_o = CmdReject;
          else if (st_i.action == ActDealloc && st_i.small_req) cmd_o = CmdPush;
          else if (st_i.action == ActInsert && st_i.cnt_zero) cmd_o = CmdReject;
          else cmd_o = CmdThrInit;
        end else cmd_o = CmdReject;
      end
      SThread: cmd_o = st_i.thr_last ? CmdThrEnd : CmdThrStep;
      SSrchRd: cmd_o = CmdSrchRd;
      SSrch: begin
        priority if (st_i.srch_end) cmd_o = CmdFail;
        else if (st_i.srch_hit) cmd_o = CmdNone;
        else cmd_o = CmdSrchStep;
      end
      // link after the run end is only ready in the cycle after the hit
      SUnlink: cmd_o = CmdUnlink;
      SOut: cmd_o = CmdNone;
      default: cmd_o = CmdNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i) state_q <= SDecode;
        SDecode: begin
          unique case (cmd_o)
            CmdThrInit: state_q <= SThread;
            CmdSrchInit: state_q <= SSrchRd;
            default: state_q <= SOut;
          endcase
        end
        SThread: if (st_i.thr_last) state_q <= SOut;
        SSrchRd: state_q <= SSrch;
        SSrch: begin
          priority if (st_i.srch_end) state_q <= SOut;
          else if (st_i.srch_hit) state_q <= SUnlink;
          else state_q <= SSrchRd;
        end
        SUnlink: state_q <= SOut;
        SOut: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  `NPFL_ASSERT_IMP(a_rdy_out_excl, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `NPFL_ASSERT_NXT(a_accept_decode, clk_i, rst_ni, in_valid_i && in_ready_o,
                   state_q == SDecode)
  `NPFL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

[hw/rtl/npfl_dp.sv]
// Datapath of the node pool free list core: link memory, head, counters.
// Depends on npfl_pkg.
`timescale 1ns / 1ps
module npfl_dp import npfl_pkg::*; #(
  parameter int unsigned PoolNodes = PoolNodesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_e              cmd_i,
  output status_t           st_o,
  input  logic [ActW-1:0]   action_i,
  input  logic [IdxW-1:0]   node_index_i,
  input  logic [BytesW-1:0] byte_count_i,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  output logic [IdxW-1:0]   result_node_o,
  output logic              ok_o,
  output logic [CntW-1:0]   free_count_o,
  output logic [CntW-1:0]   used_count_o,
  output logic [CntW-1:0]   peak_used_o
);
  localparam int unsigned PW = $clog2(PoolNodes);
  localparam int unsigned LW = PW + 1;
  localparam logic [LW-1:0] NullLink = LW'(PoolNodes);
  localparam int unsigned SW = PW + 2;

  logic [LW-1:0] link_mem [PoolNodes];
  logic [LW-1:0] rd_q;

  logic [CfgW-1:0] lg_q;
  logic [ActW-1:0] act_q;
  logic [IdxW-1:0] idx_q;
  logic [BytesW-1:0] bytes_q;
  logic [LW-1:0] head_q, cur_q, last_q, first_q, prev_q;
  logic [LW-1:0] cnt_q, have_q;
  logic [SW-1:0] steps_q;
  logic [CntW-1:0] free_q, used_q, peak_q;
  logic [IdxW-1:0] res_q;
  logic ok_q;

  logic [3:0] lg_eff;
  logic [BytesW-1:0] n_bytes;
  logic [LW-1:0] idx_ext, room, cnt_rg;
  logic [BytesW:0] have_bytes;

  always_comb begin
    lg_eff = (lg_q < 4'd3) ? 4'd3 : ((lg_q > 4'd12) ? 4'd12 : lg_q);
    n_bytes = bytes_q >> lg_eff;
    idx_ext = LW'(idx_q);
    room = NullLink - idx_ext;
    cnt_rg = (n_bytes > BytesW'(room)) ? room : LW'(n_bytes);
    have_bytes = (BytesW+1)'(have_q + LW'(1)) << lg_eff;
  end

  function automatic logic [CntW-1:0] sadd(logic [CntW-1:0] a, logic [LW-1:0] b);
    logic [CntW+LW:0] s;
    s = (CntW+LW+1)'(a) + (CntW+LW+1)'(b);
    return (s > (CntW+LW+1)'(CountMax)) ? CountMax : CntW'(s);
  endfunction
  function automatic logic [CntW-1:0] ssub(logic [CntW-1:0] a, logic [LW-1:0] b);
    return ((CntW+LW)'(a) > (CntW+LW)'(b)) ? CntW'((CntW+LW)'(a) - (CntW+LW)'(b))
                                           : '0;
  endfunction

  logic [BytesW:0] nb_full;
  assign nb_full = (BytesW+1)'(1) << lg_eff;
  assign st_o.head_null = (head_q == NullLink);
  assign st_o.small_req = ((BytesW+1)'(bytes_q) <= nb_full);
  assign st_o.idx_bad = ((IdxW+1)'(idx_q) >= (IdxW+1)'(PoolNodes));
  assign st_o.cnt_zero = (cnt_rg == '0);
  assign st_o.thr_last = (cnt_q == LW'(1));
  assign st_o.srch_end = (rd_q == NullLink) || (steps_q >= SW'(PoolNodes));
  assign st_o.srch_hit = (rd_q == last_q + LW'(1)) &&
                         (have_bytes >= (BytesW+1)'(bytes_q));
  assign st_o.action = act_q;

  // link memory: one write port, two registered read ports (rd_q and after_q)
  logic mem_we;
  logic [PW-1:0] mem_wa, mem_ra;
  logic [LW-1:0] mem_wd;
  always_comb begin
    mem_we = 1'b0; mem_wa = cur_q[PW-1:0]; mem_wd = cur_q + LW'(1);
    mem_ra = head_q[PW-1:0];
    unique case (cmd_i)
      CmdPush: begin mem_we = 1'b1; mem_wa = idx_q[PW-1:0]; mem_wd = head_q; end
      CmdThrStep: begin mem_we = 1'b1; end
      CmdThrEnd: begin mem_we = 1'b1; mem_wd = head_q; end
      CmdUnlink: begin
        mem_we = (prev_q != NullLink); mem_wa = prev_q[PW-1:0]; mem_wd = '0;
      end
      CmdSrchRd: mem_ra = last_q[PW-1:0];
      default: ;
    endcase
  end
  // unlink writes the link read after the run end; that value is the link of the node rd_q held at the hit
  logic [LW-1:0] after_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_wa] <= (cmd_i == CmdUnlink) ? after_q : mem_wd;
    rd_q <= link_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= 4'd3; head_q <= NullLink; free_q <= '0; used_q <= '0; peak_q <= '0;
      ok_q <= 1'b0; res_q <= '0;
    end else begin
      if (cfg_we_i) lg_q <= cfg_data_i;
      unique case (cmd_i)
        CmdLoad: begin
          act_q <= action_i; idx_q <= node_index_i; bytes_q <= byte_count_i;
          ok_q <= 1'b0; res_q <= '0;
        end
        CmdPop: begin
          // rd_q holds link of head (read each idle/decode cycle)
          res_q <= IdxW'(head_q); head_q <= rd_q; ok_q <= 1'b1;
          free_q <= ssub(free_q, LW'(1));
          used_q <= sadd(used_q, LW'(1));
          if (sadd(used_q, LW'(1)) > peak_q) peak_q <= sadd(used_q, LW'(1));
        end
        CmdPush: begin
          head_q <= idx_ext; free_q <= sadd(free_q, LW'(1));
          used_q <= ssub(used_q, LW'(1)); ok_q <= 1'b1;
        end
        CmdThrInit: begin cur_q <= idx_ext; cnt_q <= cnt_rg; have_q <= cnt_rg; end
        CmdThrStep: begin cur_q <= cur_q + LW'(1); cnt_q <= cnt_q - LW'(1); end
        CmdThrEnd: begin
          head_q <= idx_ext; free_q <= sadd(free_q, have_q); ok_q <= 1'b1;
          if (act_q == ActDealloc) used_q <= ssub(used_q, have_q);
        end
        CmdSrchInit: begin
          prev_q <= NullLink; first_q <= head_q; last_q <= head_q;
          have_q <= LW'(1); steps_q <= '0;
        end
        CmdSrchStep: begin
          steps_q <= steps_q + SW'(1);
          last_q <= rd_q;
          if (rd_q != last_q + LW'(1)) begin
            prev_q <= last_q; first_q <= rd_q; have_q <= LW'(1);
          end else have_q <= have_q + LW'(1);
        end
        CmdUnlink: begin
          res_q <= IdxW'(first_q); ok_q <= 1'b1;
          if (prev_q == NullLink) head_q <= after_q;
          free_q <= ssub(free_q, have_q + LW'(1));
          used_q <= sadd(used_q, have_q + LW'(1));
          if (sadd(used_q, have_q + LW'(1)) > peak_q) peak_q <= sadd(used_q, have_q + LW'(1));
        end
        default: ;
      endcase
    end
  end

  // link of the run end: read through a further register after rd_q, so unlink waits for it
  always_ff @(posedge clk_i) begin
    after_q <= link_mem[rd_q[PW-1:0]];
  end

  assign result_node_o = res_q;
  assign ok_o = ok_q;
  assign free_count_o = free_q;
  assign used_count_o = used_q;
  assign peak_used_o = peak_q;
endmodule

[hw/rtl/node_pool_free_list_core.sv]
// Node pool free list core: 1 word in, 1 word out per operation.
// Single-node allocate/free and rejects: the result follows decode, in the output state.
// Region insert/free: links the region node by node in the thread state, then the result.
// Run search: read and check states per link; a hit adds an unlink state.
// One operation at a time; the link memory reads set the pace.
// Async active-low reset empties the list and clears counters; links stay unset.
`timescale 1ns / 1ps
module node_pool_free_list_core import npfl_pkg::*; #(
  parameter int unsigned PoolNodes = PoolNodesDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_we_i,
  input logic [CfgW-1:0] cfg_data_i,
  npfl_if.sink   in_if,
  npfl_if.source out_if
);
  status_t st;
  cmd_e cmd;
  npfl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_ready_i(out_if.ready), .out_valid_o(out_if.valid), .st_i(st), .cmd_o(cmd)
  );
  npfl_dp #(.PoolNodes(PoolNodes)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .st_o(st),
    .action_i(in_if.data.action), .node_index_i(in_if.data.node_index),
    .byte_count_i(in_if.data.byte_count), .cfg_we_i, .cfg_data_i,
    .result_node_o(out_if.data.result_node), .ok_o(out_if.data.ok),
    .free_count_o(out_if.data.free_count), .used_count_o(out_if.data.used_count),
    .peak_used_o(out_if.data.peak_used)
  );
endmodule
